FILE: hw/rtl/pll_pkg.sv
// Package for the positional linked list core: command and status codes,
// and the request and response item types; the checker uses the response type.
// No dependencies.
`timescale 1ns / 1ps

package pll_pkg;

	localparam int PosW = 16;
	localparam int ValW = 32;
	localparam int LenW = 9;

	// Command codes carried in req_t.cmd. Code 3 is unused and answered as invalid.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// Status codes carried in rsp_t.status.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [1:0]             cmd;
		logic [PosW-1:0]        position;
		logic signed [ValW-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic signed [ValW-1:0] result_value;
		logic [LenW-1:0]        length;
	} rsp_t;

endpackage

FILE: hw/rtl/pll_store.sv
// Node pool storage: the value and link memories with one shared read address.
// Depends on pll_pkg for the value width.
`timescale 1ns / 1ps

module pll_store #(
	parameter int PoolDepth = 256,
	localparam int IdxW = $clog2(PoolDepth),
	localparam int PtrW = $clog2(PoolDepth + 1)
) (
	input  logic                     clk,
	input  logic [PtrW-1:0]          rd_addr,
	input  logic                     wr_link_en,
	input  logic                     wr_val_en,
	input  logic [IdxW-1:0]          wr_addr,
	input  logic [PtrW-1:0]          wr_link,
	input  logic [pll_pkg::ValW-1:0] wr_val,
	input  logic [PtrW-1:0]          fill,
	output logic [PtrW-1:0]          rd_link,
	output logic [pll_pkg::ValW-1:0] rd_val
);

	logic [PtrW-1:0]          link_mem [PoolDepth];
	logic [pll_pkg::ValW-1:0] val_mem  [PoolDepth];

	logic [PtrW-1:0]          link_s1;
	logic [PtrW-1:0]          rd_addr_s1;

	always_ff @(posedge clk) begin
		if (wr_link_en) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (wr_val_en) begin
			val_mem[wr_addr] <= wr_val;
		end
		link_s1    <= link_mem[rd_addr[IdxW-1:0]];
		rd_val     <= val_mem[rd_addr[IdxW-1:0]];
		rd_addr_s1 <= rd_addr;
	end

	// Nodes at or above the fill mark have never been written; their link is
	// still the initial free chaining, which points at the following node.
	assign rd_link = (rd_addr_s1 >= fill) ? (rd_addr_s1 + PtrW'(1)) : link_s1;

endmodule

FILE: hw/rtl/positional_linked_list_core.sv
// Top level of the positional linked list core: command sequencer and list registers.
// Depends on pll_pkg and pll_store.
`timescale 1ns / 1ps

// The core keeps an ordered singly linked list of signed 32-bit values in a pool
// of POOL_DEPTH nodes and runs one command at a time: insert at a 1-based
// position, delete at a position, or read the value at a position. A command is
// taken when start is high and busy is low; exactly one result item follows,
// shown on rsp for a single cycle with done high, and the receiver must take it
// then since the core cannot hold it. A command with a bad position, an unused
// command code, or an insert into a full pool is answered straight from the
// check state, with no walk. A valid command walks the links from the head, one
// node per cycle through the link memory's read port, then applies its link
// writes (an insert in INS_FREE, and INS_PREV past the first element; a delete in
// DEL_VIC and DEL_FREE); a read answers at the end of the walk. The result appears
// in the cycle that busy drops, and a new command may be started in that same
// cycle. No clearing pass is needed after reset: a fill mark tells which nodes
// still carry their initial free chaining, so the core is ready once reset is released.
module positional_linked_list_core #(
	parameter int POOL_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pll_pkg::req_t req,
	output logic          done,
	output pll_pkg::rsp_t rsp
);

	localparam int IdxW = $clog2(POOL_DEPTH);
	localparam int PtrW = $clog2(POOL_DEPTH + 1);
	localparam int CmpW = ((PtrW > pll_pkg::PosW) ? PtrW : pll_pkg::PosW) + 1;
	localparam logic [PtrW-1:0] NullPtr = PtrW'(POOL_DEPTH);

	// WALK follows links toward the target node. The INS and DEL states apply
	// the link changes, at most one link write per cycle.
	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_CHECK    = 7'b0000010,
		S_WALK     = 7'b0000100,
		S_INS_FREE = 7'b0001000,
		S_INS_PREV = 7'b0010000,
		S_DEL_VIC  = 7'b0100000,
		S_DEL_FREE = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// List registers. The fill mark counts the nodes that have ever been handed out.
	logic [PtrW-1:0] head_q, head_d;
	logic [PtrW-1:0] free_q, free_d;
	logic [PtrW-1:0] count_q, count_d;
	logic [PtrW-1:0] fill_q, fill_d;

	// Command registers.
	logic [1:0]                      cmd_q, cmd_d;
	logic [pll_pkg::PosW-1:0]        pos_q, pos_d;
	logic signed [pll_pkg::ValW-1:0] val_q, val_d;

	// Walk registers: current node, follows still to go, the node being added or
	// removed, and the successor that a new node will link to.
	logic [PtrW-1:0]          cur_q, cur_d;
	logic [pll_pkg::PosW-1:0] steps_q, steps_d;
	logic [PtrW-1:0]          node_q, node_d;
	logic [PtrW-1:0]          nxt_q, nxt_d;

	logic          done_q, done_d;
	pll_pkg::rsp_t rsp_q, rsp_d;

	// Memory port.
	logic [PtrW-1:0]          rd_addr;
	logic                     wr_link_en;
	logic                     wr_val_en;
	logic [IdxW-1:0]          wr_addr;
	logic [PtrW-1:0]          wr_link;
	logic [pll_pkg::ValW-1:0] wr_val;
	logic [PtrW-1:0]          rd_link;
	logic [pll_pkg::ValW-1:0] rd_val;

	// Bound checks, compared at a width that holds both the position and count + 1.
	logic [CmpW-1:0] pos_x;
	logic [CmpW-1:0] cnt_x;
	logic            pos_zero;
	logic            pos_one;
	logic            pool_full;
	logic            bad_ins;
	logic            bad_pos;

	assign pos_x     = CmpW'(pos_q);
	assign cnt_x     = CmpW'(count_q);
	assign pos_zero  = (pos_q == '0);
	assign pos_one   = (pos_q == pll_pkg::PosW'(1));
	assign pool_full = (count_q >= NullPtr) || (free_q >= NullPtr);
	assign bad_ins   = pos_x > (cnt_x + CmpW'(1));
	assign bad_pos   = pos_zero || (count_q == '0) || (pos_x > cnt_x);

	pll_store #(
		.PoolDepth(POOL_DEPTH)
	) u_store (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.wr_link_en (wr_link_en),
		.wr_val_en  (wr_val_en),
		.wr_addr    (wr_addr),
		.wr_link    (wr_link),
		.wr_val     (wr_val),
		.fill       (fill_q),
		.rd_link    (rd_link),
		.rd_val     (rd_val)
	);

	// Reads and writes never overlap on one entry: every write happens after any walk
	// has finished, and the next command's first read is issued from the check state
	// after a pass through idle, so the sequencing itself serves as the interlock.
	always_comb begin
		state_d    = state_q;
		head_d     = head_q;
		free_d     = free_q;
		count_d    = count_q;
		fill_d     = fill_q;
		cmd_d      = cmd_q;
		pos_d      = pos_q;
		val_d      = val_q;
		cur_d      = cur_q;
		steps_d    = steps_q;
		node_d     = node_q;
		nxt_d      = nxt_q;
		done_d     = 1'b0;
		rsp_d      = rsp_q;
		rd_addr    = head_q;
		wr_link_en = 1'b0;
		wr_val_en  = 1'b0;
		wr_addr    = cur_q[IdxW-1:0];
		wr_link    = node_q;
		wr_val     = val_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_d   = req.cmd;
					pos_d   = req.position;
					val_d   = req.value;
					state_d = S_CHECK;
				end
			end

			S_CHECK: begin
				rsp_d.status       = pll_pkg::ST_INVALID;
				rsp_d.result_value = '0;
				rsp_d.length       = pll_pkg::LenW'(count_q);
				cur_d              = head_q;
				rd_addr            = head_q;
				case (cmd_q)
					pll_pkg::CMD_INSERT: begin
						if (pos_zero || bad_ins || pool_full) begin
							if (!pos_zero && pool_full) begin
								rsp_d.status = pll_pkg::ST_FULL;
							end
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else if (pos_one) begin
							node_d  = free_q;
							nxt_d   = head_q;
							rd_addr = free_q;
							state_d = S_INS_FREE;
						end else begin
							node_d  = free_q;
							steps_d = pos_q - pll_pkg::PosW'(2);
							state_d = S_WALK;
						end
					end
					pll_pkg::CMD_DELETE: begin
						if (bad_pos) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else if (pos_one) begin
							node_d  = head_q;
							state_d = S_DEL_VIC;
						end else begin
							steps_d = pos_q - pll_pkg::PosW'(2);
							state_d = S_WALK;
						end
					end
					pll_pkg::CMD_READ: begin
						if (bad_pos) begin
							done_d  = 1'b1;
							state_d = S_IDLE;
						end else begin
							steps_d = pos_q - pll_pkg::PosW'(1);
							state_d = S_WALK;
						end
					end
					default: begin
						done_d  = 1'b1;
						state_d = S_IDLE;
					end
				endcase
			end

			S_WALK: begin
				// rd_link and rd_val belong to cur_q here.
				if (steps_q != '0) begin
					cur_d   = rd_link;
					rd_addr = rd_link;
					steps_d = steps_q - pll_pkg::PosW'(1);
				end else begin
					case (cmd_q)
						pll_pkg::CMD_INSERT: begin
							nxt_d   = rd_link;
							rd_addr = free_q;
							state_d = S_INS_FREE;
						end
						pll_pkg::CMD_DELETE: begin
							node_d  = rd_link;
							rd_addr = rd_link;
							state_d = S_DEL_VIC;
						end
						default: begin
							rsp_d.status       = pll_pkg::ST_DONE;
							rsp_d.result_value = rd_val;
							rsp_d.length       = pll_pkg::LenW'(count_q);
							done_d             = 1'b1;
							state_d            = S_IDLE;
						end
					endcase
				end
			end

			S_INS_FREE: begin
				// rd_link is the successor of the node taken from the free chain.
				wr_link_en = 1'b1;
				wr_val_en  = 1'b1;
				wr_addr    = node_q[IdxW-1:0];
				wr_link    = nxt_q;
				free_d     = rd_link;
				if (node_q == fill_q) begin
					fill_d = fill_q + PtrW'(1);
				end
				if (pos_one) begin
					head_d             = node_q;
					count_d            = count_q + PtrW'(1);
					rsp_d.status       = pll_pkg::ST_DONE;
					rsp_d.result_value = '0;
					rsp_d.length       = pll_pkg::LenW'(count_q + PtrW'(1));
					done_d             = 1'b1;
					state_d            = S_IDLE;
				end else begin
					state_d = S_INS_PREV;
				end
			end

			S_INS_PREV: begin
				wr_link_en         = 1'b1;
				wr_addr            = cur_q[IdxW-1:0];
				wr_link            = node_q;
				count_d            = count_q + PtrW'(1);
				rsp_d.status       = pll_pkg::ST_DONE;
				rsp_d.result_value = '0;
				rsp_d.length       = pll_pkg::LenW'(count_q + PtrW'(1));
				done_d             = 1'b1;
				state_d            = S_IDLE;
			end

			S_DEL_VIC: begin
				// The victim's value and successor are on the read port now.
				val_d = rd_val;
				if (pos_one) begin
					head_d = rd_link;
				end else begin
					wr_link_en = 1'b1;
					wr_addr    = cur_q[IdxW-1:0];
					wr_link    = rd_link;
				end
				state_d = S_DEL_FREE;
			end

			S_DEL_FREE: begin
				wr_link_en         = 1'b1;
				wr_addr            = node_q[IdxW-1:0];
				wr_link            = free_q;
				free_d             = node_q;
				count_d            = count_q - PtrW'(1);
				rsp_d.status       = pll_pkg::ST_DONE;
				rsp_d.result_value = val_q;
				rsp_d.length       = pll_pkg::LenW'(count_q - PtrW'(1));
				done_d             = 1'b1;
				state_d            = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= NullPtr;
			free_q  <= '0;
			count_q <= '0;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			count_q <= count_d;
			fill_q  <= fill_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		pos_q   <= pos_d;
		val_q   <= val_d;
		cur_q   <= cur_d;
		steps_q <= steps_d;
		node_q  <= node_d;
		nxt_q   <= nxt_d;
		rsp_q   <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

FILE: hw/rtl/pll_checker.sv
// Port-level checker for the positional linked list core, bound to the top level.
// Depends on pll_pkg and positional_linked_list_core.
`timescale 1ns / 1ps

module pll_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input pll_pkg::rsp_t rsp
);

	// A taken command always keeps the core busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("core not busy after taking an item");

	// A result is only shown once the core has gone idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// The cycle in which busy falls always shows a result.
	a_fall_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("command ended without a result");

	// Results never come in consecutive cycles.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// A failed command returns no value.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != pll_pkg::ST_DONE) |-> (rsp.result_value == '0))
		else $error("failed command returned a nonzero value");

endmodule

bind positional_linked_list_core pll_checker u_pll_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
